// ===== design/dis_pkg.sv =====
package dis_pkg;

    localparam int ITEM_COUNT = 12;
    localparam int CNT_W      = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
    localparam int POS_W      = 4;
    localparam int VAL_W      = 32;

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ITEM_COUNT - 1);

    // One slot of the sorting chain
    typedef struct packed {
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } t_slot;

    // Controller to datapath commands
    typedef struct packed {
        logic             insert;
        logic             shift;
        logic [CNT_W-1:0] fill;
    } t_dp_cmd;

    // Low POS_W bits of an arrival count, zero-extended when the count is narrower
    function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[POS_W-1:0];
    endfunction

endpackage

// ===== design/dis_ctrl.sv =====
module dis_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_sample_valid,
    output logic            o_sample_ready,
    output logic            o_result_valid,
    input  logic            i_result_ready,
    output logic            o_batch_end,
    output dis_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [0:0] {
        S_LOAD,
        S_DRAIN
    } t_state;

    t_state                    r_state, n_state;
    logic [dis_pkg::CNT_W-1:0] r_count, n_count;
    logic                      w_last;
    logic                      w_in_acc;
    logic                      w_out_acc;

    assign o_sample_ready = (r_state == S_LOAD);
    assign o_result_valid = (r_state == S_DRAIN);
    assign w_last         = (r_count == dis_pkg::LAST_IDX);
    assign o_batch_end    = o_result_valid && w_last;
    assign w_in_acc       = i_sample_valid && o_sample_ready;
    assign w_out_acc      = o_result_valid && i_result_ready;

    assign o_cmd.insert = w_in_acc;
    assign o_cmd.shift  = w_out_acc;
    assign o_cmd.fill   = r_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_last) begin
                        n_state = S_DRAIN;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    if (w_last) begin
                        n_state = S_LOAD;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/dis_chain.sv =====
module dis_chain (
    input  logic                             i_clk,
    input  dis_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [dis_pkg::VAL_W-1:0] i_sample_value,
    output logic [dis_pkg::POS_W-1:0]        o_source_position,
    output logic signed [dis_pkg::VAL_W-1:0] o_ranked_value
);

    localparam int N = dis_pkg::ITEM_COUNT;

    dis_pkg::t_slot r_slot [N];
    dis_pkg::t_slot n_slot [N];
    dis_pkg::t_slot w_new;
    logic [N-1:0]   w_keep;

    assign w_new.pos = dis_pkg::to_pos(i_cmd.fill);
    assign w_new.val = i_sample_value;

    // A filled slot holding a value >= the new one stays put (stable for ties).
    // The kept slots form a prefix, since the chain is sorted high to low.
    for (genvar i = 0; i < N; i++) begin : g_slot
        assign w_keep[i] = (32'(i_cmd.fill) > 32'(i)) && (r_slot[i].val >= i_sample_value);

        always_comb begin
            n_slot[i] = r_slot[i];
            if (i_cmd.insert) begin
                if (!w_keep[i]) begin
                    if (i == 0) begin
                        n_slot[i] = w_new;
                    end else if (w_keep[(i == 0) ? 0 : i-1]) begin
                        n_slot[i] = w_new;
                    end else begin
                        n_slot[i] = r_slot[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (i_cmd.shift && (i < N-1)) begin
                n_slot[i] = r_slot[(i < N-1) ? i+1 : i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot[i] <= n_slot[i];
        end
    end

    assign o_source_position = r_slot[0].pos;
    assign o_ranked_value    = r_slot[0].val;

endmodule

// ===== design/descending_index_sorter.sv =====
// Stable descending sort of a batch of ITEM_COUNT signed values.
// The first result is valid in the cycle after the last sample of a batch.
// Loading and draining alternate: no sample of the next batch is taken until
// the batch end result is taken; the chain has a single insert/shift port.
// Reset (synchronous, active low) returns to loading an empty batch; the
// chain contents are left as they are.
module descending_index_sorter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample channel
    input  logic                             i_sample_valid,
    output logic                             o_sample_ready,
    input  logic signed [dis_pkg::VAL_W-1:0] i_sample_value,
    // result channel
    output logic                             o_result_valid,
    input  logic                             i_result_ready,
    output logic [dis_pkg::POS_W-1:0]        o_source_position,
    output logic signed [dis_pkg::VAL_W-1:0] o_ranked_value,
    output logic                             o_batch_end
);

    // Controller: counts samples in while loading, results out while draining.
    // Sample ready and result valid come straight from its state, so the two
    // phases never overlap and a stalled result simply holds the chain.
    dis_pkg::t_dp_cmd w_cmd;

    dis_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_batch_end    (o_batch_end),
        .o_cmd          (w_cmd)
    );

    // Datapath: a chain of slots kept sorted high to low. Each sample is inserted
    // behind all slots with an equal or higher value; during drain the chain shifts
    // toward slot 0, which is the output register.
    dis_chain u_chain (
        .i_clk             (i_clk),
        .i_cmd             (w_cmd),
        .i_sample_value    (i_sample_value),
        .o_source_position (o_source_position),
        .o_ranked_value    (o_ranked_value)
    );

endmodule

// ===== design/dis_checker.sv =====
module dis_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_sample_valid,
    input logic                             o_sample_ready,
    input logic                             o_result_valid,
    input logic                             i_result_ready,
    input logic [dis_pkg::POS_W-1:0]        o_source_position,
    input logic signed [dis_pkg::VAL_W-1:0] o_ranked_value,
    input logic                             o_batch_end
);

    // loading and draining never overlap
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_sample_ready && o_result_valid))
        else $error("sample ready during drain");

    // end of batch goes back to loading
    a_end_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && i_result_ready && o_batch_end) |=> o_sample_ready)
        else $error("no return to load after batch end");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !i_result_ready) |=>
            (o_result_valid && $stable(o_ranked_value) && $stable(o_source_position)
             && $stable(o_batch_end)))
        else $error("stalled result changed");

    // ranking is descending within a batch
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && i_result_ready && !o_batch_end) |=>
            (o_result_valid && ($past(o_ranked_value) >= o_ranked_value)))
        else $error("results out of order");

endmodule

bind descending_index_sorter dis_checker u_dis_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_sample_valid    (i_sample_valid),
    .o_sample_ready    (o_sample_ready),
    .o_result_valid    (o_result_valid),
    .i_result_ready    (i_result_ready),
    .o_source_position (o_source_position),
    .o_ranked_value    (o_ranked_value),
    .o_batch_end       (o_batch_end)
);

// ===== tb/descending_index_sorter_tb.sv =====
module descending_index_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 3 * dis_pkg::ITEM_COUNT;
    localparam int BATCHES_EACH = 9;

    // one ranked result as the block should present it
    typedef struct {
        logic [dis_pkg::POS_W-1:0]        pos;
        logic signed [dis_pkg::VAL_W-1:0] val;
        logic                             last;
    } t_ranked;

    // shape of the values inside a random batch
    typedef enum int {
        MIX_WIDE,       // any 32-bit value
        MIX_TIES,       // a handful of small values, lots of ties
        MIX_EXTREMES,   // values at and next to the signed limits
        MIX_RISING,     // already ascending, the worst case for a descending sort
        MIX_FALLING     // already in output order
    } t_mix;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_sample_valid = 1'b0;
    logic                             o_sample_ready;
    logic signed [dis_pkg::VAL_W-1:0] i_sample_value = '0;
    logic                             o_result_valid;
    logic                             i_result_ready = 1'b0;
    logic [dis_pkg::POS_W-1:0]        o_source_position;
    logic signed [dis_pkg::VAL_W-1:0] o_ranked_value;
    logic                             o_batch_end;

    descending_index_sorter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sample_valid    (i_sample_valid),
        .o_sample_ready    (o_sample_ready),
        .i_sample_value    (i_sample_value),
        .o_result_valid    (o_result_valid),
        .i_result_ready    (i_result_ready),
        .o_source_position (o_source_position),
        .o_ranked_value    (o_ranked_value),
        .o_batch_end       (o_batch_end)
    );

    always #4 i_clk = ~i_clk;

    // samples waiting to be offered, and ranked results waiting to come out
    logic signed [dis_pkg::VAL_W-1:0] sample_q[$];
    t_ranked                          ranked_due[$];

    // predictor state: the batch as loaded so far
    logic signed [dis_pkg::VAL_W-1:0] batch_vals[dis_pkg::ITEM_COUNT];
    int                               batch_fill = 0;

    // idle percentages of the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches     = 0;
    int samples_taken  = 0;
    int batches_ranked = 0;
    int results_seen   = 0;
    int cycles         = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] ERROR %s", $realtime, what);
        mismatches++;
    endtask

    // Store one accepted sample; on the last of a batch, rank it stably from
    // highest to lowest and queue every result in output order.
    task automatic load_sample(input logic signed [dis_pkg::VAL_W-1:0] v);
        int      order[dis_pkg::ITEM_COUNT];
        int      j;
        int      p;
        t_ranked r;
        batch_vals[batch_fill] = v;
        batch_fill++;
        samples_taken++;
        if (batch_fill == dis_pkg::ITEM_COUNT) begin
            // insertion sort on positions; strict compare keeps earlier arrivals first
            for (int i = 0; i < dis_pkg::ITEM_COUNT; i++) begin
                j = i;
                while (j > 0 && batch_vals[order[j-1]] < batch_vals[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (int k = 0; k < dis_pkg::ITEM_COUNT; k++) begin
                p      = order[k];
                r.pos  = dis_pkg::POS_W'(p);
                r.val  = batch_vals[p];
                r.last = (k == dis_pkg::ITEM_COUNT - 1);
                ranked_due.push_back(r);
            end
            batch_fill = 0;
            batches_ranked++;
        end
    endtask

    // Driver: offers queued samples, idling at random between them. Valid and
    // payload each get exactly one assignment per edge.
    always @(posedge i_clk) begin : drive_samples
        logic                             nxt_valid;
        logic signed [dis_pkg::VAL_W-1:0] nxt_value;
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
            i_sample_value <= '0;
        end else begin
            nxt_valid = i_sample_valid;
            nxt_value = i_sample_value;
            if (i_sample_valid && o_sample_ready) begin
                load_sample(i_sample_value);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt_valid = 1'b1;
                    nxt_value = sample_q.pop_front();
                end else begin
                    // junk on the bus while idle; must be ignored
                    nxt_value = $urandom();
                end
            end
            i_sample_valid <= nxt_valid;
            i_sample_value <= nxt_value;
        end
    end

    // Monitor: stalls at random and checks every accepted result against the
    // oldest one predicted.
    always @(posedge i_clk) begin : watch_results
        t_ranked want;
        if (!i_rst_n) begin
            i_result_ready <= 1'b0;
        end else begin
            if (o_result_valid && i_result_ready) begin
                if (ranked_due.size() == 0) begin
                    report_mismatch($sformatf("result pos %0d val %0d with none pending",
                                              o_source_position, o_ranked_value));
                end else begin
                    want = ranked_due.pop_front();
                    if (o_source_position !== want.pos)
                        report_mismatch($sformatf("source_position got %0d want %0d",
                                                  o_source_position, want.pos));
                    if (o_ranked_value !== want.val)
                        report_mismatch($sformatf("ranked_value got %0d want %0d",
                                                  o_ranked_value, want.val));
                    if (o_batch_end !== want.last)
                        report_mismatch($sformatf("batch_end got %0b want %0b",
                                                  o_batch_end, want.last));
                    results_seen++;
                end
            end
            i_result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, ranked_due.size());
            $display("descending_index_sorter: mismatch");
            $finish;
        end
    end

    function automatic logic signed [dis_pkg::VAL_W-1:0] pick_extreme();
        case ($urandom_range(6))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sh7ffffffe;
            3:       return 32'sh80000001;
            4:       return -32'sd1;
            5:       return 32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

    task automatic queue_random_batch();
        t_mix mix;
        int   run;
        mix = t_mix'($urandom_range(MIX_FALLING));
        run = int'($urandom_range(4000)) - 2000;
        for (int i = 0; i < dis_pkg::ITEM_COUNT; i++) begin
            case (mix)
                MIX_WIDE:     sample_q.push_back($urandom());
                MIX_TIES:     sample_q.push_back(int'($urandom_range(4)) - 2);
                MIX_EXTREMES: sample_q.push_back(pick_extreme());
                MIX_RISING: begin
                    run += int'($urandom_range(40));
                    sample_q.push_back(run);
                end
                MIX_FALLING: begin
                    run -= int'($urandom_range(40));
                    sample_q.push_back(run);
                end
                default:      sample_q.push_back($urandom());
            endcase
        end
    endtask

    // Sender holds off until every predicted result has been taken
    task automatic wait_drained();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || i_sample_valid || ranked_due.size() != 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int b = 0; b < BATCHES_EACH; b++) queue_random_batch();
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed batch one: signed limits, zero, +/-1, and a tie on the max
        // and on zero so that order among equals shows.
        sample_q.push_back(32'sd0);
        sample_q.push_back(32'sh7fffffff);
        sample_q.push_back(32'sh80000000);
        sample_q.push_back(-32'sd1);
        sample_q.push_back(32'sd1);
        sample_q.push_back(32'sh7fffffff);
        sample_q.push_back(32'sd0);
        sample_q.push_back(32'sh80000001);
        sample_q.push_back(32'sd12345);
        sample_q.push_back(-32'sd12345);
        sample_q.push_back(32'sh55555555);
        sample_q.push_back(32'shaaaaaaaa);
        // Directed batch two: all equal, must come out in arrival order
        for (int i = 0; i < dis_pkg::ITEM_COUNT; i++) sample_q.push_back(-32'sd250);
        wait_drained();

        // Random phases: free flow, slow sender, slow receiver, both a little
        run_phase(0, 0);
        run_phase(70, 0);
        run_phase(0, 70);
        run_phase(6, 6);

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ranked %0d batches from %0d samples, %0d results checked",
                 batches_ranked, samples_taken, results_seen);
        $display("phases: directed limits and ties, then random under four idle mixes");
        if (mismatches == 0 && ranked_due.size() == 0) begin
            $display("descending_index_sorter: match");
        end else begin
            $display("descending_index_sorter: mismatch");
        end
        $finish;
    end

endmodule
